@@ src/triangle_plane_slice_top_assert.svh @@
// Assertion macros shared by the triangle plane slicer RTL.
`ifndef TRIANGLE_PLANE_SLICE_TOP_ASSERT_SVH
`define TRIANGLE_PLANE_SLICE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define TPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define TPS_ASSERT_IMPL(lbl, ante, cons)
`define TPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/tps_pkg.sv @@
// Shared types and constants of the triangle plane slicer.
package tps_pkg;

  localparam int CW     = 32;
  localparam int PROD_W = 64;
  localparam int D_W    = 50;
  localparam int MAG_W  = 50;
  localparam int SUM_W  = 51;
  localparam int T_W    = 32;
  localparam int SQ_W   = 64;
  localparam int DIST_W = 66;
  localparam int NCAND  = 6;
  localparam int NPAIR  = 15;
  localparam int NLEAF  = 16;
  localparam int ADDR_W = 5;
  localparam int IN_W   = 288;
  localparam int OUT_W  = 192;

  // Register indexes, at byte address 4 * index.
  localparam logic [2:0] REG_PLANE_A = 3'd0;
  localparam logic [2:0] REG_PLANE_B = 3'd1;
  localparam logic [2:0] REG_PLANE_C = 3'd2;
  localparam logic [2:0] REG_PLANE_D = 3'd3;
  localparam logic [2:0] REG_ZBAND   = 3'd4;
  localparam logic [2:0] REG_MERGE   = 3'd5;

  localparam logic [15:0] MERGE_RESET = 16'd7;

  // Candidate pairs in (first, second) search order.
  localparam logic [2:0] PAIR_A [NPAIR] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
                                            3'd1, 3'd1, 3'd1, 3'd1, 3'd2,
                                            3'd2, 3'd2, 3'd3, 3'd3, 3'd4};
  localparam logic [2:0] PAIR_B [NPAIR] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
                                            3'd2, 3'd3, 3'd4, 3'd5, 3'd3,
                                            3'd4, 3'd5, 3'd4, 3'd5, 3'd5};

  typedef enum logic [1:0] {
    SIDE_NONE,
    SIDE_BOTH,
    SIDE_CROSS,
    SIDE_FIRST
  } side_kind_e;

  // One point: x in the low word, then y, then z.
  typedef logic [2:0][CW-1:0] pt_t;

  typedef struct packed {
    logic [CW-1:0] plane_a;
    logic [CW-1:0] plane_b;
    logic [CW-1:0] plane_c;
    logic [CW-1:0] plane_d;
    logic [15:0]   zero_band;
    logic [15:0]   merge_dist;
    logic [31:0]   merge_sq;
  } cfg_t;

  // Classified triangle side, ready for the crossing divider.
  typedef struct packed {
    side_kind_e          kind;
    logic [MAG_W-1:0]    num;
    logic [SUM_W-1:0]    den;
    logic [2:0][CW-1:0]  dmag;
    logic [2:0]          dneg;
  } side_t;

  typedef struct packed {
    pt_t   [2:0] v;
    side_t [2:0] s;
  } qe_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    pt_t [NCAND-1:0]  p;
    logic [NCAND-1:0] vld;
  } cand_t;

endpackage

@@ src/tps_front.sv @@
// Front end: takes triangles, computes plane distances and classifies the sides.
module tps_front import tps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  pt_t  [2:0]   in_vert_i,
  input  q_stat_t      q_stat_i,
  output logic         push_o,
  output qe_t          push_data_o
);

  logic                     fe;
  logic [2:0]               vld_q;
  pt_t  [2:0]               v0_q, v1_q, v2_q;
  logic [2:0][2:0][PROD_W-1:0] prod_d, prod_q;
  logic signed [D_W-1:0]    dist_d [3];
  logic signed [D_W-1:0]    dist_q [3];
  logic [MAG_W-1:0]         mag [3];
  logic [2:0]               inb, pos, neg;
  logic signed [D_W-1:0]    zbs;
  logic                     skip;

  // The whole front advances unless a classified word waits on a full queue.
  assign fe         = !(vld_q[2] && q_stat_i.full);
  assign in_ready_o = fe;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (fe) begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      v0_q   <= in_vert_i;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      prod_q <= prod_d;
      for (int i = 0; i < 3; i++) begin
        dist_q[i] <= dist_d[i];
      end
    end
  end

  // Coefficient times coordinate, exact.
  always_comb begin
    logic signed [CW-1:0]     ca, cb;
    logic signed [PROD_W-1:0] pp;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        case (k)
          0:       ca = $signed(cfg_i.plane_a);
          1:       ca = $signed(cfg_i.plane_b);
          default: ca = $signed(cfg_i.plane_c);
        endcase
        cb = $signed(v0_q[i][k]);
        pp = ca * cb;
        prod_d[i][k] = pp;
      end
    end
  end

  // Floor each product to Q16.16 and add the constant term.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dist_d[i] = D_W'($signed(cfg_i.plane_d))
                + D_W'($signed(prod_q[i][0][PROD_W-1:16]))
                + D_W'($signed(prod_q[i][1][PROD_W-1:16]))
                + D_W'($signed(prod_q[i][2][PROD_W-1:16]));
    end
  end

  // Band tests and the one-sided skip.
  always_comb begin
    zbs = $signed(D_W'(cfg_i.zero_band));
    for (int i = 0; i < 3; i++) begin
      mag[i] = dist_q[i][D_W-1] ? (~dist_q[i] + 1'b1) : dist_q[i];
      inb[i] = mag[i] < MAG_W'(cfg_i.zero_band);
      pos[i] = dist_q[i] > zbs;
      neg[i] = dist_q[i] < -zbs;
    end
    skip = (&pos) || (&neg);
  end

  // Per side: kind, divider operands and coordinate differences.
  always_comb begin
    logic signed [CW:0] df;
    push_data_o.v = v2_q;
    for (int i = 0; i < 3; i++) begin
      if (inb[i] && inb[(i + 1) % 3]) begin
        push_data_o.s[i].kind = SIDE_BOTH;
      end else if ((dist_q[i] < 0 && dist_q[(i + 1) % 3] > 0) ||
                   (dist_q[i] > 0 && dist_q[(i + 1) % 3] < 0)) begin
        push_data_o.s[i].kind = SIDE_CROSS;
      end else if (inb[i]) begin
        push_data_o.s[i].kind = SIDE_FIRST;
      end else begin
        push_data_o.s[i].kind = SIDE_NONE;
      end
      push_data_o.s[i].num = mag[i];
      push_data_o.s[i].den = SUM_W'(mag[i]) + SUM_W'(mag[(i + 1) % 3]);
      for (int k = 0; k < 3; k++) begin
        df = $signed({v2_q[(i + 1) % 3][k][CW-1], v2_q[(i + 1) % 3][k]})
           - $signed({v2_q[i][k][CW-1], v2_q[i][k]});
        push_data_o.s[i].dneg[k] = df[CW];
        push_data_o.s[i].dmag[k] = df[CW] ? CW'(-df) : df[CW-1:0];
      end
    end
  end

  assign push_o = vld_q[2] && !skip && fe;

endmodule

@@ src/tps_queue.sv @@
// Short queue between the classifying front and the slicing back end.
module tps_queue import tps_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qe_t     push_data_i,
  input  logic    pop_i,
  output qe_t     head_o,
  output q_stat_t stat_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qe_t              mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == CNT_W'(DEPTH);
  assign stat_o.empty = cnt_q == '0;

endmodule

@@ src/tps_back.sv @@
// Back end: pipelined crossing divider, interpolation and candidate slots.
module tps_back import tps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    be_i,
  input  q_stat_t q_stat_i,
  input  qe_t     head_i,
  output logic    pop_o,
  output logic    cand_valid_o,
  output cand_t   cand_o
);

  typedef struct packed {
    qe_t                     item;
    logic [2:0][SUM_W-1:0]   rem;
    logic [2:0][T_W-1:0]     quo;
  } div_t;

  div_t                     dv_q [T_W];
  div_t                     dv_d [T_W];
  logic [T_W-1:0]           dv_vld_q;
  qe_t                      mul_item_q;
  logic [2:0][2:0][SQ_W-1:0] mul_d, mul_q;
  logic                     mul_vld_q;
  cand_t                    cand_d, cand_q;
  logic                     cand_vld_q;

  assign pop_o = be_i && !q_stat_i.empty;

  // One quotient bit per stage for each of the three sides.
  for (genvar g = 0; g < T_W; g++) begin : g_div
    div_t src;
    if (g == 0) begin : g_first
      always_comb begin
        src.item = head_i;
        for (int e = 0; e < 3; e++) begin
          src.rem[e] = SUM_W'(head_i.s[e].num);
          src.quo[e] = '0;
        end
      end
    end else begin : g_next
      assign src = dv_q[g-1];
    end

    always_comb begin
      logic [SUM_W:0] r2, dd;
      logic           ge;
      dv_d[g].item = src.item;
      for (int e = 0; e < 3; e++) begin
        r2 = {src.rem[e], 1'b0};
        dd = {1'b0, src.item.s[e].den};
        ge = r2 >= dd;
        dv_d[g].rem[e] = ge ? SUM_W'(r2 - dd) : SUM_W'(r2);
        dv_d[g].quo[e] = {src.quo[e][T_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (be_i) begin
        dv_q[g] <= dv_d[g];
      end
    end
  end

  // Fraction times coordinate span.
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        mul_d[e][k] = SQ_W'(dv_q[T_W-1].item.s[e].dmag[k]) * SQ_W'(dv_q[T_W-1].quo[e]);
      end
    end
  end

  // Round the offset half up and lay out the candidate slots in side order.
  always_comb begin
    logic [SQ_W-1:0] rs;
    logic [CW-1:0]   off;
    pt_t             xp;
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        rs    = mul_q[e][k] + (SQ_W'(1) << (T_W - 1));
        off   = rs[SQ_W-1:T_W];
        xp[k] = mul_item_q.s[e].dneg[k] ? mul_item_q.v[e][k] - off
                                        : mul_item_q.v[e][k] + off;
      end
      cand_d.p[2*e]     = (mul_item_q.s[e].kind == SIDE_CROSS) ? xp : mul_item_q.v[e];
      cand_d.vld[2*e]   = mul_item_q.s[e].kind != SIDE_NONE;
      cand_d.p[2*e+1]   = mul_item_q.v[(e + 1) % 3];
      cand_d.vld[2*e+1] = mul_item_q.s[e].kind == SIDE_BOTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q   <= '0;
      mul_vld_q  <= 1'b0;
      cand_vld_q <= 1'b0;
    end else if (be_i) begin
      dv_vld_q   <= {dv_vld_q[T_W-2:0], pop_o};
      mul_vld_q  <= dv_vld_q[T_W-1];
      cand_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be_i) begin
      mul_item_q <= dv_q[T_W-1].item;
      mul_q      <= mul_d;
      cand_q     <= cand_d;
    end
  end

  assign cand_valid_o = cand_vld_q;
  assign cand_o       = cand_q;

endmodule

@@ src/tps_select.sv @@
// Merges near-duplicate candidates and picks the farthest pair as the segment.
module tps_select import tps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  be_i,
  input  cfg_t  cfg_i,
  input  logic  cand_valid_i,
  input  cand_t cand_i,
  output logic  out_valid_o,
  output pt_t   out_start_o,
  output pt_t   out_end_o
);

  localparam int NSTG = 8;

  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] span;
    logic [2:0]        a;
    logic [2:0]        b;
  } node_t;

  // Left wins ties, so the earliest pair in search order is kept.
  function automatic node_t pick(node_t l, node_t r);
    node_t res;
    res = (l.vld && (!r.vld || l.span >= r.span)) ? l : r;
    return res;
  endfunction

  logic [NSTG-1:0]            sv_q;
  cand_t                      cp_q [NSTG];
  logic [NPAIR-1:0][2:0][CW-1:0]   m_d, m_q;
  logic [NPAIR-1:0][2:0][SQ_W-1:0] sq_d, sq_q;
  logic [NPAIR-1:0]           lt_d, lt_q, near_d, near_q;
  logic [DIST_W-1:0]          dist_d [NPAIR];
  logic [DIST_W-1:0]          dist_q [NPAIR];
  logic [NCAND-1:0]           dup, uniq;
  node_t                      lv0_d [NLEAF];
  node_t                      lv0_q [NLEAF];
  node_t                      lv1_d [8];
  node_t                      lv1_q [8];
  node_t                      lv2_d [4];
  node_t                      lv2_q [4];
  node_t                      lv3_d [2];
  node_t                      lv3_q [2];
  node_t                      lv4_q;
  logic                       out_vld_q;
  pt_t                        start_q, end_q;

  // Per-coordinate distance magnitudes for every pair.
  always_comb begin
    logic signed [CW:0] df;
    for (int p = 0; p < NPAIR; p++) begin
      for (int k = 0; k < 3; k++) begin
        df = $signed({cand_i.p[PAIR_B[p]][k][CW-1], cand_i.p[PAIR_B[p]][k]})
           - $signed({cand_i.p[PAIR_A[p]][k][CW-1], cand_i.p[PAIR_A[p]][k]});
        m_d[p][k] = df[CW] ? CW'(-df) : df[CW-1:0];
      end
    end
  end

  // Squares, and whether every axis lies inside the merge radius.
  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      lt_d[p] = 1'b1;
      for (int k = 0; k < 3; k++) begin
        sq_d[p][k] = SQ_W'(m_q[p][k]) * SQ_W'(m_q[p][k]);
        if (m_q[p][k] >= CW'(cfg_i.merge_dist)) begin
          lt_d[p] = 1'b0;
        end
      end
    end
  end

  // Exact squared distance and the merge decision.
  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      dist_d[p] = DIST_W'(sq_q[p][0]) + DIST_W'(sq_q[p][1]) + DIST_W'(sq_q[p][2]);
      near_d[p] = lt_q[p] && (dist_d[p] < DIST_W'(cfg_i.merge_sq));
    end
  end

  // A candidate close to any earlier candidate drops out; leaves are surviving pairs.
  always_comb begin
    dup = '0;
    for (int p = 0; p < NPAIR; p++) begin
      if (cp_q[2].vld[PAIR_A[p]] && near_q[p]) begin
        dup[PAIR_B[p]] = 1'b1;
      end
    end
    uniq = cp_q[2].vld & ~dup;
    for (int p = 0; p < NLEAF; p++) begin
      lv0_d[p] = '0;
    end
    for (int p = 0; p < NPAIR; p++) begin
      lv0_d[p].vld  = uniq[PAIR_A[p]] && uniq[PAIR_B[p]];
      lv0_d[p].span = dist_q[p];
      lv0_d[p].a    = PAIR_A[p];
      lv0_d[p].b    = PAIR_B[p];
    end
  end

  // Farthest-pair tree, one level per stage.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lv1_d[i] = pick(lv0_q[2*i], lv0_q[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      lv2_d[i] = pick(lv1_q[2*i], lv1_q[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      lv3_d[i] = pick(lv2_q[2*i], lv2_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (be_i) begin
      sv_q      <= {sv_q[NSTG-2:0], cand_valid_i};
      out_vld_q <= sv_q[NSTG-1] && lv4_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be_i) begin
      cp_q[0] <= cand_i;
      for (int s = 1; s < NSTG; s++) begin
        cp_q[s] <= cp_q[s-1];
      end
      m_q    <= m_d;
      sq_q   <= sq_d;
      lt_q   <= lt_d;
      near_q <= near_d;
      for (int p = 0; p < NPAIR; p++) begin
        dist_q[p] <= dist_d[p];
      end
      for (int p = 0; p < NLEAF; p++) begin
        lv0_q[p] <= lv0_d[p];
      end
      for (int i = 0; i < 8; i++) begin
        lv1_q[i] <= lv1_d[i];
      end
      for (int i = 0; i < 4; i++) begin
        lv2_q[i] <= lv2_d[i];
      end
      for (int i = 0; i < 2; i++) begin
        lv3_q[i] <= lv3_d[i];
      end
      lv4_q   <= pick(lv3_q[0], lv3_q[1]);
      start_q <= cp_q[NSTG-1].p[lv4_q.a];
      end_q   <= cp_q[NSTG-1].p[lv4_q.b];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_start_o = start_q;
  assign out_end_o   = end_q;

endmodule

@@ src/triangle_plane_slice_top.sv @@
// Triangle plane slicer top level: config registers, front, queue and back end.
// Throughput: one triangle word per cycle; a stalled output stalls the back end at once
// and the front once the queue is full.
// Path: the result word passes through three front stages, a queue slot, the 32-stage
// divider, two interpolation stages, eight selection stages and the output register
// (the first front stage loads at the input accept edge).
// Reset clears all valid bits, the queue and the registers (merge distance resets to 7).
`include "triangle_plane_slice_top_assert.svh"
module triangle_plane_slice_top import tps_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, 32 bits each
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, 32 bits each
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  logic [CW-1:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q;
  logic [15:0]   zband_q, merge_q;
  logic [31:0]   merge_sq_q;
  logic          wr_en;
  logic [2:0]    reg_idx;
  logic          be;
  logic          q_push, q_pop;
  qe_t           q_in, q_head;
  q_stat_t       q_stat;
  logic          cand_vld;
  cand_t         cand;
  pt_t           seg_start, seg_end;

  // Register file.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_a_q  <= '0;
      plane_b_q  <= '0;
      plane_c_q  <= '0;
      plane_d_q  <= '0;
      zband_q    <= '0;
      merge_q    <= MERGE_RESET;
      merge_sq_q <= 32'(MERGE_RESET) * 32'(MERGE_RESET);
    end else begin
      merge_sq_q <= 32'(merge_q) * 32'(merge_q);
      if (wr_en) begin
        case (reg_idx)
          REG_PLANE_A: plane_a_q <= pwdata;
          REG_PLANE_B: plane_b_q <= pwdata;
          REG_PLANE_C: plane_c_q <= pwdata;
          REG_PLANE_D: plane_d_q <= pwdata;
          REG_ZBAND:   zband_q   <= pwdata[15:0];
          REG_MERGE:   merge_q   <= pwdata[15:0];
          default:     ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PLANE_A: prdata = plane_a_q;
      REG_PLANE_B: prdata = plane_b_q;
      REG_PLANE_C: prdata = plane_c_q;
      REG_PLANE_D: prdata = plane_d_q;
      REG_ZBAND:   prdata = 32'(zband_q);
      REG_MERGE:   prdata = 32'(merge_q);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.plane_a    = plane_a_q;
    cfg.plane_b    = plane_b_q;
    cfg.plane_c    = plane_c_q;
    cfg.plane_d    = plane_d_q;
    cfg.zero_band  = zband_q;
    cfg.merge_dist = merge_q;
    cfg.merge_sq   = merge_sq_q;
  end

  // The back end moves whenever the output register is free or being emptied.
  assign be = !m_axis_tvalid || m_axis_tready;

  tps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_vert_i   (s_axis_tdata),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_data_o (q_in)
  );

  tps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  tps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .be_i         (be),
    .q_stat_i     (q_stat),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .cand_valid_o (cand_vld),
    .cand_o       (cand)
  );

  tps_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .be_i         (be),
    .cfg_i        (cfg),
    .cand_valid_i (cand_vld),
    .cand_i       (cand),
    .out_valid_o  (m_axis_tvalid),
    .out_start_o  (seg_start),
    .out_end_o    (seg_end)
  );

  assign m_axis_tdata = {seg_end, seg_start};

  // Queue bookkeeping between front and back end.
  `TPS_ASSERT_IMPL(a_push_has_room, q_push, !q_stat.full)
  `TPS_ASSERT_IMPL(a_pop_has_word, q_pop, !q_stat.empty)
  `TPS_ASSERT_NEXT(a_full_keeps_word, q_stat.full && !q_pop, !q_stat.empty)

endmodule

@@ tb/tb_triangle_plane_slice_top.sv @@
// Self-checking testbench for the triangle plane slicer: random and directed triangles.
module tb_triangle_plane_slice_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tps_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_ITEMS    = 260;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  triangle_plane_slice_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the plane and band registers.
  longint          coef_a, coef_b, coef_c, coef_d;
  longint          band_w;
  longint unsigned merge_w;
  int              plane_h;

  logic [IN_W-1:0]  tri_pending [$];
  logic [OUT_W-1:0] seg_expected [$];
  int               err_count;
  int               cyc;
  int               quiet_cnt;
  bit               word_taken;

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned abs_u(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint sx32(input logic [31:0] w);
    return longint'(signed'(w));
  endfunction

  // Slices one triangle word; returns 1 with the segment when one comes out.
  function automatic bit slice_triangle(input logic [IN_W-1:0] w, output logic [OUT_W-1:0] seg);
    longint          vtx [3][3];
    longint          pdist [3];
    longint          cand [6][3];
    longint          uniq [6][3];
    longint          da, db, diff;
    longint unsigned s, r, t, off, m, sum, sq, hi, lo, best_hi, best_lo;
    int              nc, nu, n, first, second;
    bit              dup, fits;
    nc = 0;
    nu = 0;
    first = 0;
    second = 1;
    best_hi = 0;
    best_lo = 0;
    seg = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) vtx[i][k] = sx32(w[32*(3*i+k) +: 32]);
      pdist[i] = ((coef_a * vtx[i][0]) >>> 16) + ((coef_b * vtx[i][1]) >>> 16)
               + ((coef_c * vtx[i][2]) >>> 16) + coef_d;
    end
    // Whole triangle on one side of the band.
    if ((pdist[0] > band_w && pdist[1] > band_w && pdist[2] > band_w) ||
        (pdist[0] < -band_w && pdist[1] < -band_w && pdist[2] < -band_w)) return 1'b0;
    // Edge walk collecting candidate points.
    for (int i = 0; i < 3; i++) begin
      n = (i + 1) % 3;
      da = pdist[i];
      db = pdist[n];
      if (abs_u(da) < band_w && abs_u(db) < band_w) begin
        cand[nc] = vtx[i];
        cand[nc+1] = vtx[n];
        nc += 2;
      end else if ((da < 0 && db > 0) || (da > 0 && db < 0)) begin
        s = abs_u(da) + abs_u(db);
        r = abs_u(da);
        t = 0;
        for (int b = 0; b < 32; b++) begin
          r = r << 1;
          t = t << 1;
          if (r >= s) begin
            r = r - s;
            t = t | 64'd1;
          end
        end
        for (int k = 0; k < 3; k++) begin
          diff = vtx[n][k] - vtx[i][k];
          off = (abs_u(diff) * t + 64'h8000_0000) >> 32;
          cand[nc][k] = (diff < 0) ? vtx[i][k] - longint'(off) : vtx[i][k] + longint'(off);
        end
        nc++;
      end else if (abs_u(da) < band_w) begin
        cand[nc] = vtx[i];
        nc++;
      end
    end
    // Drop near duplicates of earlier points.
    for (int i = 0; i < nc; i++) begin
      dup = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (!dup) begin
          sum = 0;
          fits = 1'b1;
          for (int k = 0; k < 3; k++) begin
            m = abs_u(cand[i][k] - cand[j][k]);
            if (m >= merge_w) fits = 1'b0;
            sum += m * m;
          end
          if (fits && sum < merge_w * merge_w) dup = 1'b1;
        end
      end
      if (!dup) begin
        uniq[nu] = cand[i];
        nu++;
      end
    end
    if (nu < 2) return 1'b0;
    // Farthest pair, first found wins ties.
    for (int i = 0; i < nu; i++) begin
      for (int j = i + 1; j < nu; j++) begin
        hi = 0;
        lo = 0;
        for (int k = 0; k < 3; k++) begin
          m = abs_u(uniq[i][k] - uniq[j][k]);
          sq = m * m;
          lo += sq;
          if (lo < sq) hi++;
        end
        if (hi > best_hi || (hi == best_hi && lo > best_lo)) begin
          best_hi = hi;
          best_lo = lo;
          first = i;
          second = j;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      seg[32*k +: 32] = uniq[first][k][31:0];
      seg[96+32*k +: 32] = uniq[second][k][31:0];
    end
    return 1'b1;
  endfunction

  // Coordinate near the plane height, or anywhere.
  function automatic logic [31:0] pick_coord(input bit height);
    case ($urandom_range(5))
      0, 1: return $urandom_range(0, 1 << 20) - (1 << 19);
      2:    return height ? plane_h : $urandom_range(0, 255);
      3:    return height ? plane_h + $urandom_range(0, 200) - 100 : 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] make_triangle(input bit wild);
    logic [IN_W-1:0] w;
    for (int i = 0; i < 9; i++)
      w[32*i +: 32] = wild ? $urandom : pick_coord((i % 3) == 2);
    // Repeated or nearly repeated vertices exercise the merge.
    case ($urandom_range(7))
      0: w[96 +: 96] = w[0 +: 96];
      1: for (int k = 0; k < 3; k++) w[192+32*k +: 32] = w[32*k +: 32] + $urandom_range(0, 8);
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [IN_W-1:0] same_triangle(input logic [31:0] c);
    logic [IN_W-1:0] w;
    for (int i = 0; i < 9; i++) w[32*i +: 32] = c;
    return w;
  endfunction

  // One register write, setup then access cycle.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PLANE_A: coef_a = sx32(val);
      REG_PLANE_B: coef_b = sx32(val);
      REG_PLANE_C: coef_c = sx32(val);
      REG_PLANE_D: coef_d = sx32(val);
      REG_ZBAND:   band_w = val[15:0];
      REG_MERGE:   merge_w = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_plane(input logic [31:0] a, b, c, d, input logic [15:0] zb, md);
    reg_write(REG_PLANE_A, a);
    reg_write(REG_PLANE_B, b);
    reg_write(REG_PLANE_C, c);
    reg_write(REG_PLANE_D, d);
    reg_write(REG_ZBAND, {16'd0, zb});
    reg_write(REG_MERGE, {16'd0, md});
  endtask

  // Waits until every triangle is taken and every segment has arrived.
  task automatic drain();
    do @(negedge clk_i);
    while (tri_pending.size() != 0 || seg_expected.size() != 0 || s_axis_tvalid);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input bit wild);
    logic [IN_W-1:0] w;
    // Short directed set: extremes, coplanar, one and two vertices on the plane.
    tri_pending.insert(tri_pending.size(), same_triangle(32'h7fff_ffff));
    tri_pending.insert(tri_pending.size(), same_triangle(32'h8000_0000));
    tri_pending.insert(tri_pending.size(), same_triangle(plane_h));
    tri_pending.insert(tri_pending.size(), same_triangle(32'd0));
    w = same_triangle(plane_h);
    w[0 +: 32] = 32'h0001_0000;
    w[128 +: 32] = 32'h0002_0000;
    w[160 +: 32] = plane_h + 32'h0003_0000;
    tri_pending.insert(tri_pending.size(), w);
    w[64 +: 32] = plane_h - 32'h0001_8000;
    tri_pending.insert(tri_pending.size(), w);
    for (int i = 0; i < PHASE_ITEMS; i++)
      tri_pending.insert(tri_pending.size(),
                         make_triangle(wild || ($urandom_range(9) == 0)));
    drain();
  endtask

  // Input driver: holds a word until it is taken, idles at random.
  always @(negedge clk_i) begin
    cyc <= cyc + 1;
    if (!(s_axis_tvalid && !word_taken)) begin
      if (tri_pending.size() != 0 && (quiet_cnt > 0 || $urandom_range(99) >= 16)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= tri_pending[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= (quiet_cnt > 0) || ($urandom_range(99) >= 16);
    quiet_cnt <= (cyc % 4000 == 1000) ? 700 : ((quiet_cnt > 0) ? quiet_cnt - 1 : 0);
    word_taken = 1'b0;
  end

  // Accept monitor, segment checker and watchdog.
  int               idle_cycles;
  logic [OUT_W-1:0] seg_pred;
  logic [OUT_W-1:0] seg_want;
  string            seg_field [6] = '{"start_x", "start_y", "start_z", "end_x", "end_y", "end_z"};
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles = idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        word_taken = 1'b1;
        if (slice_triangle(tri_pending[0], seg_pred))
          seg_expected.insert(seg_expected.size(), seg_pred);
        void'(tri_pending.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        if (seg_expected.size() == 0) begin
          $error("segment word with none expected: %h", m_axis_tdata);
          err_count++;
        end else begin
          seg_want = seg_expected.pop_front();
          for (int k = 0; k < 6; k++)
            if (m_axis_tdata[32*k +: 32] !== seg_want[32*k +: 32]) begin
              $error("%s expected %h actual %h", seg_field[k],
                     seg_want[32*k +: 32], m_axis_tdata[32*k +: 32]);
              err_count++;
            end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Reset, then configuration phases from defaults to extremes.
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    cyc = 0;
    quiet_cnt = 0;
    idle_cycles = 0;
    word_taken = 1'b0;
    coef_a = 0;
    coef_b = 0;
    coef_c = 0;
    coef_d = 0;
    band_w = 0;
    merge_w = longint'(MERGE_RESET);
    plane_h = 5 << 16;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: a null plane, so nothing comes out.
    run_phase(1'b0);
    set_plane(32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd7);
    run_phase(1'b0);
    set_plane(32'd0, 32'd0, 32'h0001_0000, -plane_h, 16'd0, 16'd7);
    run_phase(1'b0);
    set_plane(32'd0, 32'd0, 32'h0001_0000, -plane_h, 16'hffff, 16'd0);
    run_phase(1'b0);
    set_plane($urandom, $urandom, $urandom, $urandom, $urandom, 16'hffff);
    run_phase(1'b1);
    set_plane(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, -plane_h, 16'd1000, 16'd300);
    run_phase(1'b0);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
